// ----- rtl/core/doaf_pkg.sv -----
// shared types, codes and constants for the distance outlier average filter
// no dependencies; used by every file of the block but doaf_div
package doaf_pkg;

  localparam int DATA_W    = 13;
  localparam int PCT_W     = 7;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam int RING_DEPTH_DEF = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH    = 1'd1;

  localparam logic [DATA_W-1:0] MAX_DEPTH_RST = 13'd1110;
  localparam logic [DATA_W-1:0] THRESH_RST    = 13'd200;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [STAT_W-1:0] STAT_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ACCEPT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTLIER = 2'd2;
  localparam logic [STAT_W-1:0] STAT_REFILL  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_TEST,
    ST_SUM2,
    ST_MSTART,
    ST_MWAIT,
    ST_PMUL,
    ST_PSTART,
    ST_PWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic fill_all;
  } ring_wr_t;

endpackage

// ----- rtl/core/doaf_if.sv -----
// request and result channel interfaces of the distance outlier average filter
// depends on doaf_pkg
interface doaf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       sample_valid;
  logic [doaf_pkg::DATA_W-1:0] distance_mm;

  modport source (output valid, output sample_valid, output distance_mm, input ready);
  modport sink (input valid, input sample_valid, input distance_mm, output ready);
endinterface

interface doaf_out_if;
  logic                        valid;
  logic                        ready;
  logic [doaf_pkg::DATA_W-1:0] mean_depth_mm;
  logic [doaf_pkg::PCT_W-1:0]  fill_percent;
  logic [doaf_pkg::STAT_W-1:0] sample_status;

  modport source (output valid, output mean_depth_mm, output fill_percent,
                  output sample_status, input ready);
  modport sink (input valid, input mean_depth_mm, input fill_percent,
                input sample_status, output ready);
endinterface

// ----- rtl/core/doaf_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing; shared by the mean and fill percent steps
module doaf_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/core/doaf_ring.sv -----
// sample ring: one write slot or a whole refill per cycle, one read slot
// depends on doaf_pkg
module doaf_ring #(
  parameter int RING_DEPTH = doaf_pkg::RING_DEPTH_DEF,
  parameter int SLOT_W     = 3
) (
  input  logic                        clk,
  input  doaf_pkg::ring_wr_t          wr,
  input  logic [SLOT_W-1:0]           wr_slot,
  input  logic [doaf_pkg::DATA_W-1:0] wr_data,
  input  logic [SLOT_W-1:0]           rd_slot,
  output logic [doaf_pkg::DATA_W-1:0] rd_data
);

  logic [doaf_pkg::DATA_W-1:0] ring_r [RING_DEPTH];

  always_ff @(posedge clk) begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      if (wr.fill_all || (wr.wr_en && wr_slot == SLOT_W'(k))) begin
        ring_r[k] <= wr_data;
      end
    end
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < RING_DEPTH; k++) begin
      if (rd_slot == SLOT_W'(k)) begin
        rd_data = ring_r[k];
      end
    end
  end

endmodule

// ----- rtl/core/distance_outlier_average_filter.sv -----
// top level of the distance outlier average filter: sequencer, counters, config
// depends on doaf_pkg, doaf_if, doaf_ring and doaf_div
//
// usage
//   in_req carries one distance sample and its sample_valid flag per request;
//   out_res returns one result per request: floored mean of the held samples,
//   inverted fill percent and a status code. cfg_we/cfg_index/cfg_wdata write
//   max_depth_mm (index 0) and outlier_thresh_mm (index 1); the user must write
//   them while idle only, which the block itself does not enforce. in_req.ready
//   is high only while the sequencer is idle; one request is worked at a time.
//   The bit-serial divider, with NUM_W = 13 + clog2(RING_DEPTH+1) + 7 (23 at
//   depth 5), runs once for the mean and once for the percent; the ring is
//   summed one slot per cycle. When the ring is empty after the update both
//   divisions are skipped. Reset restores the register defaults and empties
//   the ring. A result waits in an output register while out_res.ready is low;
//   the next request is still taken, and its result is held back until the
//   slot frees.
module distance_outlier_average_filter #(
  parameter int RING_DEPTH = doaf_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  doaf_in_if.sink                        in_req,
  doaf_out_if.source                     out_res,
  input  logic                           cfg_we,
  input  logic [doaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [doaf_pkg::DATA_W-1:0]    cfg_wdata
);

  localparam int DATA_W = doaf_pkg::DATA_W;
  localparam int PCT_W  = doaf_pkg::PCT_W;
  localparam int STAT_W = doaf_pkg::STAT_W;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = DATA_W + CNT_W;
  localparam int NUM_W  = SUM_W + PCT_W;
  localparam int DEN_W  = SUM_W;

  doaf_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] max_depth_r, max_depth_nxt;
  logic [DATA_W-1:0] thresh_r, thresh_nxt;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0] raw_r, raw_nxt;
  logic [SUM_W-1:0]  scaled_r, scaled_nxt;
  logic [SUM_W-1:0]  thr_r, thr_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] mean_r, mean_nxt;
  logic [PCT_W-1:0]  fill_r, fill_nxt;
  logic [NUM_W-1:0]  pnum_r, pnum_nxt;
  logic [DEN_W-1:0]  pden_r, pden_nxt;
  logic [DATA_W-1:0] out_mean_r, out_mean_nxt;
  logic [PCT_W-1:0]  out_fill_r, out_fill_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  doaf_pkg::ring_wr_t ring_wr;
  logic [DATA_W-1:0]  rd_data;
  logic               in_fire;
  logic [SUM_W-1:0]   dev;
  logic               in_band;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [PCT_W-1:0]   pct;

  doaf_ring #(
    .RING_DEPTH(RING_DEPTH),
    .SLOT_W    (SLOT_W)
  ) u_ring (
    .clk    (clk),
    .wr     (ring_wr),
    .wr_slot(slot_r),
    .wr_data(raw_r),
    .rd_slot(idx_r[SLOT_W-1:0]),
    .rd_data(rd_data)
  );

  doaf_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_fire   = in_req.valid && in_req.ready;
  assign dev       = (scaled_r >= sum_r) ? (scaled_r - sum_r) : (sum_r - scaled_r);
  assign in_band   = (held_r == '0) || (dev <= thr_r);
  assign div_start = (state_r == doaf_pkg::ST_MSTART) || (state_r == doaf_pkg::ST_PSTART);
  assign div_num   = (state_r == doaf_pkg::ST_MSTART) ? NUM_W'(sum_r) : pnum_r;
  assign div_den   = (state_r == doaf_pkg::ST_MSTART) ? DEN_W'(held_r) : pden_r;
  assign pct       = (div_quo > NUM_W'(doaf_pkg::PCT_FULL)) ? doaf_pkg::PCT_FULL
                                                            : div_quo[PCT_W-1:0];

  // config writes
  always_comb begin
    max_depth_nxt = max_depth_r;
    thresh_nxt    = thresh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        doaf_pkg::CFG_MAX_DEPTH: max_depth_nxt = cfg_wdata;
        doaf_pkg::CFG_THRESH:    thresh_nxt    = cfg_wdata;
        default:                 ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    held_nxt      = held_r;
    run_nxt       = run_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    raw_nxt       = raw_r;
    scaled_nxt    = scaled_r;
    thr_nxt       = thr_r;
    status_nxt    = status_r;
    mean_nxt      = mean_r;
    fill_nxt      = fill_r;
    pnum_nxt      = pnum_r;
    pden_nxt      = pden_r;
    out_mean_nxt  = out_mean_r;
    out_fill_nxt  = out_fill_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    ring_wr       = '0;

    unique case (state_r)
      doaf_pkg::ST_IDLE: begin
        if (in_fire) begin
          raw_nxt    = in_req.distance_mm;
          status_nxt = doaf_pkg::STAT_NONE;
          idx_nxt    = '0;
          sum_nxt    = '0;
          state_nxt  = in_req.sample_valid ? doaf_pkg::ST_SUM : doaf_pkg::ST_SUM2;
        end
      end
      doaf_pkg::ST_SUM: begin
        if (idx_r == held_r) begin
          state_nxt = doaf_pkg::ST_MUL;
        end else begin
          sum_nxt = sum_r + SUM_W'(rd_data);
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      doaf_pkg::ST_MUL: begin
        scaled_nxt = SUM_W'(raw_r) * SUM_W'(held_r);
        thr_nxt    = SUM_W'(thresh_r) * SUM_W'(held_r);
        state_nxt  = doaf_pkg::ST_TEST;
      end
      doaf_pkg::ST_TEST: begin
        if (in_band) begin
          ring_wr.wr_en = 1'b1;
          slot_nxt      = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
          if (held_r != CNT_W'(RING_DEPTH)) begin
            held_nxt = held_r + CNT_W'(1);
          end
          run_nxt    = '0;
          status_nxt = doaf_pkg::STAT_ACCEPT;
        end else if (run_r == CNT_W'(RING_DEPTH - 1)) begin
          ring_wr.fill_all = 1'b1;
          held_nxt         = CNT_W'(RING_DEPTH);
          slot_nxt         = '0;
          run_nxt          = '0;
          status_nxt       = doaf_pkg::STAT_REFILL;
        end else begin
          run_nxt    = run_r + CNT_W'(1);
          status_nxt = doaf_pkg::STAT_OUTLIER;
        end
        idx_nxt   = '0;
        sum_nxt   = '0;
        state_nxt = doaf_pkg::ST_SUM2;
      end
      doaf_pkg::ST_SUM2: begin
        if (idx_r == held_r) begin
          if (held_r == '0) begin
            mean_nxt  = '0;
            fill_nxt  = doaf_pkg::PCT_FULL;
            state_nxt = doaf_pkg::ST_OUT;
          end else begin
            state_nxt = doaf_pkg::ST_MSTART;
          end
        end else begin
          sum_nxt = sum_r + SUM_W'(rd_data);
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      doaf_pkg::ST_MSTART: begin
        state_nxt = doaf_pkg::ST_MWAIT;
      end
      doaf_pkg::ST_MWAIT: begin
        if (div_done) begin
          mean_nxt  = div_quo[DATA_W-1:0];
          state_nxt = doaf_pkg::ST_PMUL;
        end
      end
      doaf_pkg::ST_PMUL: begin
        pnum_nxt  = NUM_W'(sum_r) * NUM_W'(doaf_pkg::PCT_FULL);
        pden_nxt  = DEN_W'(held_r) * DEN_W'(max_depth_r);
        state_nxt = doaf_pkg::ST_PSTART;
      end
      doaf_pkg::ST_PSTART: begin
        state_nxt = doaf_pkg::ST_PWAIT;
      end
      doaf_pkg::ST_PWAIT: begin
        if (div_done) begin
          fill_nxt  = doaf_pkg::PCT_FULL - pct;
          state_nxt = doaf_pkg::ST_OUT;
        end
      end
      doaf_pkg::ST_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_mean_nxt  = mean_r;
          out_fill_nxt  = fill_r;
          out_stat_nxt  = status_r;
          out_valid_nxt = 1'b1;
          state_nxt     = doaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = doaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= doaf_pkg::ST_IDLE;
      idx_r       <= '0;
      held_r      <= '0;
      run_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      max_depth_r <= doaf_pkg::MAX_DEPTH_RST;
      thresh_r    <= doaf_pkg::THRESH_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      held_r      <= held_nxt;
      run_r       <= run_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      max_depth_r <= max_depth_nxt;
      thresh_r    <= thresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    raw_r      <= raw_nxt;
    scaled_r   <= scaled_nxt;
    thr_r      <= thr_nxt;
    status_r   <= status_nxt;
    mean_r     <= mean_nxt;
    fill_r     <= fill_nxt;
    pnum_r     <= pnum_nxt;
    pden_r     <= pden_nxt;
    out_mean_r <= out_mean_nxt;
    out_fill_r <= out_fill_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_req.ready          = (state_r == doaf_pkg::ST_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.mean_depth_mm = out_mean_r;
  assign out_res.fill_percent  = out_fill_r;
  assign out_res.sample_status = out_stat_r;

endmodule

// ----- rtl/core/doaf_checker.sv -----
// port-level checks for the distance outlier average filter, bound to the top
// depends on doaf_pkg and distance_outlier_average_filter
module doaf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [doaf_pkg::DATA_W-1:0]   out_mean,
  input logic [doaf_pkg::PCT_W-1:0]    out_fill,
  input logic [doaf_pkg::STAT_W-1:0]   out_status
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_fill)
      && $stable(out_status))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // fill percent is clamped
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill <= doaf_pkg::PCT_FULL)
    else $error("fill percent above full scale");

endmodule

bind distance_outlier_average_filter doaf_checker u_doaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_mean  (out_res.mean_depth_mm),
  .out_fill  (out_res.fill_percent),
  .out_status(out_res.sample_status)
);
